### hw/rtl/iso8583_pkg.sv
// Shared types, constants and field table for the ISO 8583 unpacker.
// No dependencies; used by every design module of the block except the checker.
package iso8583_pkg;

   localparam int NumSlots = 30;
   localparam logic [13:0] MaxLlllLen = 14'd99;
   localparam int QueueDepth = 4;

   typedef enum logic [2:0] {
      KIND_BCD = 3'd0,
      KIND_LLBCD = 3'd1,
      KIND_ASC = 3'd2,
      KIND_LLASC = 3'd3,
      KIND_LLLLASC = 3'd4,
      KIND_RAW = 3'd5
   } field_kind_type;

   typedef enum logic [1:0] {
      PH_LEN_HI = 2'd0,
      PH_LEN_LO = 2'd1,
      PH_SLOT = 2'd2,
      PH_DISCARD = 2'd3
   } phase_type;

   typedef struct packed {
      logic [6:0] id;
      field_kind_type kind;
      logic [6:0] size;
   } slot_desc_type;

   // One queued job: up to three results described compactly.
   typedef struct packed {
      logic [1:0] count;      // number of results (1..3)
      logic       two_chars;  // first entries are two hex digits
      logic       hex;        // characters are hex digits of data
      logic [6:0] id;
      logic [7:0] data;
      logic       last0;      // field_last of first character
      logic       last1;      // field_last of second character
      logic       has_status; // final result is a status
      logic       status;
   } job_type;

   function automatic slot_desc_type slot_desc(input logic [4:0] s);
      slot_desc_type d;
      d = '{7'd0, KIND_BCD, 7'd0};
      case (s)
         5'd0: d = '{7'd64, KIND_BCD, 7'd10};
         5'd1: d = '{7'd0, KIND_BCD, 7'd4};
         5'd2: d = '{7'd1, KIND_RAW, 7'd8};
         5'd3: d = '{7'd2, KIND_LLBCD, 7'd19};
         5'd4: d = '{7'd3, KIND_BCD, 7'd6};
         5'd5: d = '{7'd4, KIND_BCD, 7'd12};
         5'd6: d = '{7'd11, KIND_BCD, 7'd6};
         5'd7: d = '{7'd12, KIND_BCD, 7'd6};
         5'd8: d = '{7'd13, KIND_BCD, 7'd4};
         5'd9: d = '{7'd14, KIND_BCD, 7'd4};
         5'd10: d = '{7'd15, KIND_BCD, 7'd4};
         5'd11: d = '{7'd22, KIND_BCD, 7'd4};
         5'd12: d = '{7'd24, KIND_BCD, 7'd4};
         5'd13: d = '{7'd25, KIND_BCD, 7'd2};
         5'd14: d = '{7'd35, KIND_LLBCD, 7'd37};
         5'd15: d = '{7'd37, KIND_ASC, 7'd12};
         5'd16: d = '{7'd38, KIND_ASC, 7'd6};
         5'd17: d = '{7'd39, KIND_ASC, 7'd2};
         5'd18: d = '{7'd41, KIND_ASC, 7'd8};
         5'd19: d = '{7'd42, KIND_ASC, 7'd15};
         5'd20: d = '{7'd45, KIND_LLASC, 7'd76};
         5'd21: d = '{7'd49, KIND_ASC, 7'd3};
         5'd22: d = '{7'd50, KIND_ASC, 7'd3};
         5'd23: d = '{7'd54, KIND_LLLLASC, 7'd0};
         5'd24: d = '{7'd55, KIND_LLLLASC, 7'd0};
         5'd25: d = '{7'd59, KIND_LLLLASC, 7'd0};
         5'd26: d = '{7'd60, KIND_LLLLASC, 7'd0};
         5'd27: d = '{7'd61, KIND_LLLLASC, 7'd0};
         5'd28: d = '{7'd62, KIND_LLLLASC, 7'd0};
         5'd29: d = '{7'd63, KIND_LLLLASC, 7'd0};
         default: d = '{7'd0, KIND_BCD, 7'd0};
      endcase
      return d;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
   endfunction

   // Nibbles above nine still weigh ten and one, so the value reaches 165.
   function automatic logic [7:0] bcd_value(input logic [7:0] b);
      return {1'b0, b[7:4], 3'd0} + {3'd0, b[7:4], 1'b0} + {4'd0, b[3:0]};
   endfunction

endpackage

### hw/rtl/iso8583_parse.sv
// Front end: tracks frame position, bitmap and lengths, and turns each field data byte or frame end into a job.
// Depends on iso8583_pkg.
module iso8583_parse (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [7:0]             in_byte,
   output logic                   job_valid,
   input  logic                   job_ready,
   output iso8583_pkg::job_type   job
);

   iso8583_pkg::phase_type phase_ff, phase_in;
   logic [4:0]  slot_ff, slot_in;
   logic [1:0]  bcnt_ff, bcnt_in;
   logic [13:0] flen_ff, flen_in;
   logic [7:0]  lhigh_ff, lhigh_in;
   logic [15:0] decl_ff, decl_in;
   logic [15:0] cons_ff, cons_in;
   logic [63:0] bmap_ff, bmap_in;
   logic [15:0] disc_ff, disc_in;

   // Next present slot at or after slot_ff + 1, or at 0 (search over a 30-bit mask).
   logic [iso8583_pkg::NumSlots-1:0] present;
   logic [4:0] next_slot;
   logic       next_found;
   logic [4:0] search_base;
   iso8583_pkg::slot_desc_type d, nd;
   logic [7:0] b;
   logic       accept;
   logic       open_req;
   logic [14:0] l_val;
   logic [14:0] l_lim;
   logic [13:0] flen_a;

   assign b = in_byte;
   assign accept = in_valid && in_ready;
   assign in_ready = job_ready;
   assign d = iso8583_pkg::slot_desc(slot_ff);

   always_comb begin
      for (int s = 0; s < iso8583_pkg::NumSlots; s++) begin
         iso8583_pkg::slot_desc_type sd;
         sd = iso8583_pkg::slot_desc(5'(s));
         if (s < 3) begin
            present[s] = 1'b1;
         end else begin
            present[s] = bmap_in[6'(7'd64 - sd.id)];
         end
      end
   end

   always_comb begin
      next_found = 1'b0;
      next_slot = 5'd0;
      for (int s = iso8583_pkg::NumSlots - 1; s >= 0; s--) begin
         if (present[s] && (5'(s) >= search_base)) begin
            next_found = 1'b1;
            next_slot = 5'(s);
         end
      end
   end

   assign nd = iso8583_pkg::slot_desc(next_slot);

   always_comb begin
      phase_in = phase_ff;
      slot_in = slot_ff;
      bcnt_in = bcnt_ff;
      flen_in = flen_ff;
      lhigh_in = lhigh_ff;
      decl_in = decl_ff;
      cons_in = cons_ff;
      bmap_in = bmap_ff;
      disc_in = disc_ff;
      job = '0;
      job_valid = 1'b0;
      open_req = 1'b0;
      search_base = 5'd0;
      l_val = '0;
      l_lim = '0;
      flen_a = flen_ff;
      case (phase_ff)
         iso8583_pkg::PH_LEN_HI: begin
            decl_in = {b, 8'd0};
            cons_in = '0;
            bmap_in = '0;
            phase_in = iso8583_pkg::PH_LEN_LO;
         end
         iso8583_pkg::PH_LEN_LO: begin
            decl_in = {decl_ff[15:8], b};
            open_req = 1'b1;
            search_base = 5'd0;
         end
         iso8583_pkg::PH_DISCARD: begin
            if (disc_ff > 16'd1) begin
               disc_in = disc_ff - 16'd1;
            end else begin
               disc_in = '0;
               phase_in = iso8583_pkg::PH_LEN_HI;
            end
         end
         default: begin
            cons_in = cons_ff + 16'd1;
            search_base = slot_ff + 5'd1;
            if (bcnt_ff == 2'd2) begin
               lhigh_in = iso8583_pkg::bcd_value(b);
               bcnt_in = 2'd1;
            end else if (bcnt_ff == 2'd1) begin
               if (d.kind == iso8583_pkg::KIND_LLLLASC) begin
                  // 100*h = 64h + 32h + 4h
                  l_val = {1'b0, lhigh_ff, 6'd0} + {2'b0, lhigh_ff, 5'd0}
                        + {5'd0, lhigh_ff, 2'd0}
                        + {7'd0, iso8583_pkg::bcd_value(b)};
                  l_lim = {1'b0, iso8583_pkg::MaxLlllLen};
               end else begin
                  l_val = {7'd0, iso8583_pkg::bcd_value(b)};
                  l_lim = {8'd0, d.size};
               end
               flen_in = 14'((l_val > l_lim) ? l_lim : l_val);
               bcnt_in = 2'd0;
               if (flen_in == '0) open_req = 1'b1;
            end else begin
               if (flen_ff != '0) begin
                  job_valid = 1'b1;
                  job.id = d.id;
                  job.data = b;
                  if (d.kind == iso8583_pkg::KIND_BCD || d.kind == iso8583_pkg::KIND_LLBCD) begin
                     job.hex = 1'b1;
                     flen_a = flen_ff - 14'd1;
                     job.last0 = (flen_a == '0);
                     if (flen_a != '0) begin
                        job.two_chars = 1'b1;
                        flen_a = flen_a - 14'd1;
                        job.last1 = (flen_a == '0);
                        job.count = 2'd2;
                     end else begin
                        job.count = 2'd1;
                     end
                  end else begin
                     flen_a = flen_ff - 14'd1;
                     job.last0 = (flen_a == '0);
                     job.count = 2'd1;
                     if (d.kind == iso8583_pkg::KIND_RAW) bmap_in = {bmap_ff[55:0], b};
                  end
                  flen_in = flen_a;
               end
               if (flen_a == '0) open_req = 1'b1;
            end
         end
      endcase
      if (open_req) begin
         if (next_found && !(phase_ff == iso8583_pkg::PH_SLOT && slot_ff == 5'd29)) begin
            phase_in = iso8583_pkg::PH_SLOT;
            slot_in = next_slot;
            flen_in = '0;
            if (nd.kind == iso8583_pkg::KIND_LLBCD || nd.kind == iso8583_pkg::KIND_LLASC) begin
               bcnt_in = 2'd1;
            end else if (nd.kind == iso8583_pkg::KIND_LLLLASC) begin
               bcnt_in = 2'd2;
            end else begin
               bcnt_in = 2'd0;
               flen_in = {7'd0, nd.size};
            end
         end else begin
            job_valid = 1'b1;
            job.has_status = 1'b1;
            job.status = (decl_in != cons_in);
            job.count = job.count + 2'd1;
            bcnt_in = 2'd0;
            flen_in = '0;
            if (decl_in > cons_in) begin
               disc_in = decl_in - cons_in;
               phase_in = iso8583_pkg::PH_DISCARD;
            end else begin
               phase_in = iso8583_pkg::PH_LEN_HI;
            end
         end
      end
      job_valid = job_valid && accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= iso8583_pkg::PH_LEN_HI;
         slot_ff <= '0;
         bcnt_ff <= '0;
         flen_ff <= '0;
         lhigh_ff <= '0;
         decl_ff <= '0;
         cons_ff <= '0;
         bmap_ff <= '0;
         disc_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         slot_ff <= slot_in;
         bcnt_ff <= bcnt_in;
         flen_ff <= flen_in;
         lhigh_ff <= lhigh_in;
         decl_ff <= decl_in;
         cons_ff <= cons_in;
         bmap_ff <= bmap_in;
         disc_ff <= disc_in;
      end
   end

endmodule

### hw/rtl/iso8583_queue.sv
// Short job queue between the parser and the emitter.
// Depends on iso8583_pkg.
module iso8583_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   output logic                 wr_ready,
   input  iso8583_pkg::job_type wr_job,
   output logic                 rd_valid,
   input  logic                 rd_ready,
   output iso8583_pkg::job_type rd_job
);

   localparam int AddrW = $clog2(iso8583_pkg::QueueDepth);
   iso8583_pkg::job_type mem_ff [iso8583_pkg::QueueDepth];
   logic [AddrW-1:0] wptr_ff, rptr_ff;
   logic [AddrW:0]   cnt_ff, cnt_in;
   logic             push, pop;

   assign wr_ready = (cnt_ff != (AddrW+1)'(iso8583_pkg::QueueDepth));
   assign rd_valid = (cnt_ff != '0);
   assign rd_job = mem_ff[rptr_ff];
   assign push = wr_valid && wr_ready;
   assign pop = rd_valid && rd_ready;

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wptr_ff <= wptr_ff + 1'b1;
         if (pop) rptr_ff <= rptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= wr_job;
   end

endmodule

### hw/rtl/iso8583_emit.sv
// Back end: expands each queued job into one to three result transfers.
// Depends on iso8583_pkg.
module iso8583_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  iso8583_pkg::job_type job,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [17:0]          out_data,
   output logic                 out_user,
   output logic                 out_last
);

   logic [1:0] idx_ff, idx_in;
   logic       is_status;
   logic       final_one;
   logic [7:0] ch;
   logic       flast;

   assign out_valid = job_valid;
   assign final_one = ({1'b0, idx_ff} + 3'd1) == {1'b0, job.count};
   assign job_ready = out_ready && final_one;
   assign is_status = job.has_status && final_one;

   always_comb begin
      if (job.hex) begin
         ch = iso8583_pkg::hex_char((idx_ff == 2'd0) ? job.data[7:4] : job.data[3:0]);
      end else begin
         ch = job.data;
      end
      flast = (idx_ff == 2'd0) ? job.last0 : job.last1;
      idx_in = idx_ff;
      if (out_valid && out_ready) idx_in = final_one ? 2'd0 : idx_ff + 2'd1;
   end

   // tdata: field_id[6:0], data_char[14:7], field_last[15], status[16], pad
   assign out_data = is_status ? {1'b0, job.status, 16'd0}
                               : {2'd0, flast, ch, job.id};
   assign out_user = is_status;
   assign out_last = final_one;

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else idx_ff <= idx_in;
   end

endmodule

### hw/rtl/iso8583_message_unpacker_core.sv
// Top level of the ISO 8583 unpacker: parser, job queue and result emitter.
// Depends on iso8583_pkg, iso8583_parse, iso8583_queue, iso8583_emit.
//
// Channel | Direction | tdata                                   | tuser       | tlast
// req     | in        | byte_in[7:0]                            | -           | -
// rsp     | out       | field_id, data_char, field_last, status | result_kind | run_last
//
// A byte is accepted while the queue has room; results leave at one per cycle
// while rsp_tready is high, and a BCD byte yields up to two characters. The parser
// decides each byte's results in the cycle it arrives and hands them to a
// four-entry queue. Reset is synchronous and returns the frame position to the
// length prefix. Input stalls only while the queue is full.
module iso8583_message_unpacker_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // byte_in[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // field_id[6:0], data_char[14:7], field_last[15], status[16]
   output logic        rsp_tuser,   // result_kind
   output logic        rsp_tlast    // run_last
);

   iso8583_pkg::job_type pj, qj;
   logic pv, pr, qv, qr;
   logic [17:0] od;

   iso8583_parse u_parse (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready), .in_byte(req_tdata),
      .job_valid(pv), .job_ready(pr), .job(pj)
   );

   iso8583_queue u_queue (
      .clock, .reset, .wr_valid(pv), .wr_ready(pr), .wr_job(pj),
      .rd_valid(qv), .rd_ready(qr), .rd_job(qj)
   );

   iso8583_emit u_emit (
      .clock, .reset, .job_valid(qv), .job_ready(qr), .job(qj),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(od),
      .out_user(rsp_tuser), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {6'd0, od};

endmodule

### hw/rtl/iso8583_checker.sv
// Port-level checks for the ISO 8583 unpacker core.
// Depends on iso8583_message_unpacker_core; attached with a bind.
module iso8583_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   a_status_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast) else $error("status not last of run");
   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[15:0] == 16'd0) else $error("status payload");
   a_char_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> !rsp_tdata[16]) else $error("char with status");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");

endmodule

bind iso8583_message_unpacker_core iso8583_checker u_checker (.*);

### tb/sv/tb_iso8583_message_unpacker_core.sv
// Testbench for iso8583_message_unpacker_core: drives framed ISO 8583 messages byte by byte
// and checks every result against a built-in predictor. Depends on iso8583_pkg and the RTL.
`timescale 1ns / 1ps

class unpack_scoreboard;
   typedef struct packed {
      logic       kind;
      logic [6:0] id;
      logic [7:0] ch;
      logic       flast;
      logic       st;
      logic       rlast;
   } unpack_result_type;

   unpack_result_type expected_results[$];
   int unsigned phase_reg;
   int unsigned byte_count;
   int unsigned field_len;
   int unsigned len_hi_digits;
   int unsigned declared_len;
   int unsigned consumed;
   logic [63:0] bitmap;
   int unsigned discard_left;
   int errors;
   int checked;
   int frames;
   unpack_result_type pending[$];

   function new();
      phase_reg = 0;
      byte_count = 0;
      field_len = 0;
      len_hi_digits = 0;
      declared_len = 0;
      consumed = 0;
      bitmap = '0;
      discard_left = 0;
      errors = 0;
      checked = 0;
      frames = 0;
   endfunction

   function logic [7:0] to_hex(input logic [3:0] nib);
      return (nib < 10) ? 8'h30 + nib : 8'h37 + nib;
   endfunction

   function int unsigned bcd_len(input logic [7:0] b);
      return 10 * b[7:4] + b[3:0];
   endfunction

   function void push(input logic kind, input logic [6:0] id, input logic [7:0] ch,
                      input logic flast, input logic st);
      unpack_result_type r;
      r = '{kind, id, ch, flast, st, 1'b0};
      pending.push_back(r);
   endfunction

   function bit slot_present(input int s);
      iso8583_pkg::slot_desc_type d;
      d = iso8583_pkg::slot_desc(5'(s));
      if (s < 3) return 1;
      return bitmap[64 - d.id];
   endfunction

   function void open_slot(input int from);
      iso8583_pkg::slot_desc_type d;
      for (int s = from; s < iso8583_pkg::NumSlots; s++) begin
         if (slot_present(s)) begin
            d = iso8583_pkg::slot_desc(5'(s));
            phase_reg = 2 + s;
            field_len = 0;
            if (d.kind == iso8583_pkg::KIND_LLBCD || d.kind == iso8583_pkg::KIND_LLASC)
               byte_count = 1;
            else if (d.kind == iso8583_pkg::KIND_LLLLASC)
               byte_count = 2;
            else begin
               byte_count = 0;
               field_len = d.size;
            end
            return;
         end
      end
      push(1'b1, 7'd0, 8'd0, 1'b0, declared_len != consumed);
      frames++;
      byte_count = 0;
      field_len = 0;
      if (declared_len > consumed) begin
         discard_left = declared_len - consumed;
         phase_reg = 32;
      end else
         phase_reg = 0;
   endfunction

   // Notes one accepted input byte and queues the results it causes.
   function void note_byte(input logic [7:0] b);
      iso8583_pkg::slot_desc_type d;
      int unsigned l;
      int unsigned lim;
      int s;
      pending.delete();
      if (phase_reg == 0) begin
         declared_len = {b, 8'd0};
         consumed = 0;
         bitmap = '0;
         phase_reg = 1;
      end else if (phase_reg == 1) begin
         declared_len = declared_len | b;
         open_slot(0);
      end else if (phase_reg == 32) begin
         if (discard_left > 0) discard_left--;
         if (discard_left == 0) phase_reg = 0;
      end else begin
         s = phase_reg - 2;
         d = iso8583_pkg::slot_desc(5'(s));
         consumed = (consumed + 1) & 16'hFFFF;
         if (byte_count == 2) begin
            len_hi_digits = bcd_len(b);
            byte_count = 1;
         end else if (byte_count == 1) begin
            l = bcd_len(b);
            lim = d.size;
            if (d.kind == iso8583_pkg::KIND_LLLLASC) begin
               l += 100 * len_hi_digits;
               lim = iso8583_pkg::MaxLlllLen;
            end
            if (l > lim) l = lim;
            field_len = l;
            byte_count = 0;
            if (l == 0) open_slot(s + 1);
         end else begin
            if (field_len > 0) begin
               if (d.kind == iso8583_pkg::KIND_BCD || d.kind == iso8583_pkg::KIND_LLBCD) begin
                  field_len--;
                  push(1'b0, d.id, to_hex(b[7:4]), field_len == 0, 1'b0);
                  if (field_len > 0) begin
                     field_len--;
                     push(1'b0, d.id, to_hex(b[3:0]), field_len == 0, 1'b0);
                  end
               end else begin
                  field_len--;
                  if (d.kind == iso8583_pkg::KIND_RAW) bitmap = {bitmap[55:0], b};
                  push(1'b0, d.id, b, field_len == 0, 1'b0);
               end
            end
            if (field_len == 0) open_slot(s + 1);
         end
      end
      if (pending.size() > 0) pending[pending.size() - 1].rlast = 1'b1;
      foreach (pending[i]) expected_results.push_back(pending[i]);
   endfunction

   function void check_result(input unpack_result_type act);
      unpack_result_type e;
      if (expected_results.size() == 0) begin
         $display("%0t: unexpected result %h", $time, act);
         errors++;
         return;
      end
      e = expected_results.pop_front();
      checked++;
      if (e !== act) begin
         $display("%0t: mismatch expected kind=%0d id=%0d ch=%h fl=%0d st=%0d rl=%0d",
                  $time, e.kind, e.id, e.ch, e.flast, e.st, e.rlast);
         $display("%0t:          actual   kind=%0d id=%0d ch=%h fl=%0d st=%0d rl=%0d",
                  $time, act.kind, act.id, act.ch, act.flast, act.st, act.rlast);
         errors++;
      end
   endfunction
endclass

module tb_iso8583_message_unpacker_core;
   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int bytes_sent = 0;
   logic [7:0] frame_bytes[$];
   unpack_scoreboard sb = new();

   iso8583_message_unpacker_core u_top (.*);

   always #5 clock = ~clock;

   // Receiver side: random stalls and result checks.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result({rsp_tuser, rsp_tdata[6:0], rsp_tdata[14:7], rsp_tdata[15],
                             rsp_tdata[16], rsp_tlast});
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Valid stays high after a transfer until the next byte or an idle cycle replaces it.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(b);
      bytes_sent++;
   endtask

   task automatic add_bcd(input int digits);
      for (int i = 0; i < (digits + 1) / 2; i++) frame_bytes.push_back($urandom);
   endtask

   // Builds a frame with a random bitmap and random field lengths (some over the maximum), then sends it.
   task automatic send_frame(input bit broken);
      logic [63:0] bm;
      iso8583_pkg::slot_desc_type d;
      int n;
      int decl;
      frame_bytes.delete();
      bm = {$urandom, $urandom} & {$urandom, $urandom};
      if ($urandom_range(3) == 0) bm = '0;
      for (int i = 0; i < 5; i++) frame_bytes.push_back($urandom);
      frame_bytes.push_back($urandom);
      frame_bytes.push_back($urandom);
      for (int i = 7; i >= 0; i--) frame_bytes.push_back(bm[i*8 +: 8]);
      for (int s = 3; s < iso8583_pkg::NumSlots; s++) begin
         d = iso8583_pkg::slot_desc(5'(s));
         if (!bm[64 - d.id]) continue;
         case (d.kind)
            iso8583_pkg::KIND_BCD: add_bcd(d.size);
            iso8583_pkg::KIND_LLBCD: begin
               n = $urandom_range(0, d.size + ($urandom_range(4) == 0 ? 20 : 0));
               frame_bytes.push_back({4'(n / 10), 4'(n % 10)});
               add_bcd(n > d.size ? d.size : n);
            end
            iso8583_pkg::KIND_ASC:
               for (int i = 0; i < d.size; i++) frame_bytes.push_back($urandom);
            iso8583_pkg::KIND_LLASC: begin
               n = $urandom_range(0, 12);
               if ($urandom_range(7) == 0) n = 99;
               frame_bytes.push_back({4'(n / 10), 4'(n % 10)});
               for (int i = 0; i < (n > 76 ? 76 : n); i++) frame_bytes.push_back($urandom);
            end
            default: begin
               n = $urandom_range(0, 6);
               if ($urandom_range(9) == 0) n = 150;
               frame_bytes.push_back({4'(n / 1000), 4'((n / 100) % 10)});
               frame_bytes.push_back({4'((n / 10) % 10), 4'(n % 10)});
               for (int i = 0; i < (n > 99 ? 99 : n); i++) frame_bytes.push_back($urandom);
            end
         endcase
      end
      decl = frame_bytes.size();
      if (broken) decl = decl + $urandom_range(0, 6) - 3;
      if (decl < 0) decl = 0;
      send_byte(8'(decl >> 8));
      send_byte(8'(decl));
      // Stop as soon as the parser is back at a length prefix, so leftovers never
      // become a bogus frame header.
      foreach (frame_bytes[i]) begin
         if (sb.phase_reg == 0) break;
         send_byte(broken && $urandom_range(15) == 0 ? $urandom : frame_bytes[i]);
      end
      // Feed surplus bytes until the frame position is back at the length prefix.
      while (sb.phase_reg != 0) send_byte($urandom);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: a frame with an empty bitmap whose declared length leaves two
      // surplus bytes to discard.
      frame_bytes.delete();
      send_byte(8'h00); send_byte(8'h11);
      for (int i = 0; i < 7; i++) send_byte(i == 0 ? 8'hFF : 8'hAB);
      for (int i = 0; i < 8; i++) send_byte(8'h00);
      send_byte(8'hFF); send_byte(8'h00);
      send_frame(1'b0);
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = (p == 1 || p == 3) ? (p == 3 ? 29 : 67) : 0;
         recv_stall_pct = (p == 2 || p == 3) ? (p == 3 ? 29 : 67) : 0;
         while (bytes_sent < 480 * (p + 1) / 4) send_frame($urandom_range(4) == 0);
      end
      req_tvalid <= 1'b0;
      while (sb.expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d bytes in %0d frames; checked %0d results.",
               bytes_sent, sb.frames, sb.checked);
      if (sb.errors == 0 && sb.expected_results.size() == 0)
         $display("tb_iso8583_message_unpacker_core OK");
      else
         $display("tb_iso8583_message_unpacker_core NOT OK");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_iso8583_message_unpacker_core NOT OK");
      $finish;
   end
endmodule
